// ===== design/smx_pkg.sv =====
package smx_pkg;

  localparam int StackDepthDef = 1024;
  localparam int DataWordsDef  = 4096;
  localparam int ProgWordsDef  = 256;

  typedef enum logic [3:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_LDC = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_JMP = 4'd6,
    OP_BR  = 4'd7,
    OP_RET = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RET      = 3'd1,
    ST_OVER     = 3'd2,
    ST_FEW      = 3'd3,
    ST_ADDR     = 3'd4,
    ST_EMPTY_BR = 3'd5,
    ST_IGNORED  = 3'd6
  } st_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         next_pc;
    logic signed [31:0] top_value;
    logic [10:0]        stack_count;
    logic [2:0]         status;
  } out_rsp_t;

  typedef struct packed {
    logic        en;
    logic [31:0] addr;
    logic [31:0] data;
  } mem_wr_t;

endpackage

// ===== design/smx_ram.sv =====
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/smx_exec.sv =====
module smx_exec #(
  parameter int STACK_DEPTH = 1024,
  parameter int DATA_WORDS  = 4096,
  parameter int PROG_WORDS  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ex_fire,
  input  smx_pkg::in_req_t  ex_req,
  input  logic [31:0]       ld_data,
  output smx_pkg::out_rsp_t rsp,
  output smx_pkg::mem_wr_t  wr
);

  import smx_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int PW = $clog2(PROG_WORDS);
  localparam logic [31:0] DataLim = 32'(DATA_WORDS);
  localparam logic [31:0] ProgLim = 32'(PROG_WORDS);

  logic [PW-1:0] pc_r, pc_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic          halted_r, halted_nxt;
  logic [31:0]   top_r, sec_r, top_nxt;

  op_t         op;
  st_t         st;
  logic        push, jump, halt_set, wr_en;
  logic [31:0] push_val, alu, arg;
  logic        addr_ok, tgt_ok, full, empty, few;
  logic [31:0] pc_wide, sp_wide;

  assign op      = op_t'(ex_req.opcode);
  assign arg     = ex_req.operand;
  assign addr_ok = arg < DataLim;
  assign tgt_ok  = arg < ProgLim;
  assign full    = sp_r == SW'(STACK_DEPTH);
  assign empty   = sp_r == '0;
  assign few     = sp_r < SW'(2);

  always_comb begin
    case (op)
      OP_ADD:  alu = top_r + sec_r;
      OP_SUB:  alu = top_r - sec_r;
      default: begin
        if ($signed(sec_r) < $signed(top_r)) begin
          alu = 32'd1;
        end else if ($signed(top_r) < $signed(sec_r)) begin
          alu = '1;
        end else begin
          alu = '0;
        end
      end
    endcase
  end

  always_comb begin
    st       = ST_OK;
    push     = 1'b0;
    push_val = arg;
    jump     = 1'b0;
    halt_set = 1'b0;
    wr_en    = 1'b0;
    if (halted_r) begin
      st = ST_IGNORED;
    end else begin
      unique case (op) inside
        OP_LD: begin
          if (!addr_ok) begin
            st = ST_ADDR;
          end else if (full) begin
            st = ST_OVER;
          end else begin
            push     = 1'b1;
            push_val = ld_data;
          end
        end
        OP_ST: begin
          if (empty) begin
            st = ST_FEW;
          end else if (!addr_ok) begin
            st = ST_ADDR;
          end else begin
            wr_en = 1'b1;
          end
        end
        OP_LDC: begin
          if (full) begin
            st = ST_OVER;
          end else begin
            push = 1'b1;
          end
        end
        OP_ADD, OP_SUB, OP_CMP: begin
          if (few) begin
            st = ST_FEW;
          end else if (full) begin
            st = ST_OVER;
          end else begin
            push     = 1'b1;
            push_val = alu;
          end
        end
        OP_JMP: begin
          if (!tgt_ok) begin
            st = ST_ADDR;
          end else begin
            jump = 1'b1;
          end
        end
        OP_BR: begin
          if (empty) begin
            st       = ST_EMPTY_BR;
            halt_set = 1'b1;
          end else if (top_r != '0) begin
            if (!tgt_ok) begin
              st = ST_ADDR;
            end else begin
              jump = 1'b1;
            end
          end
        end
        OP_RET: begin
          st       = ST_RET;
          halt_set = 1'b1;
        end
        default: st = ST_ADDR;
      endcase
    end
  end

  always_comb begin
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    top_nxt    = top_r;
    halted_nxt = halted_r | halt_set;
    if (st == ST_OK) begin
      if (jump) begin
        pc_nxt = arg[PW-1:0];
      end else if (pc_r == PW'(PROG_WORDS - 1)) begin
        pc_nxt = '0;
      end else begin
        pc_nxt = pc_r + PW'(1);
      end
    end
    if (push) begin
      sp_nxt  = sp_r + SW'(1);
      top_nxt = push_val;
    end
  end

  assign pc_wide         = 32'(pc_nxt);
  assign sp_wide         = 32'(sp_nxt);
  assign rsp.next_pc     = pc_wide[7:0];
  assign rsp.top_value   = (sp_nxt != '0) ? top_nxt : '0;
  assign rsp.stack_count = sp_wide[10:0];
  assign rsp.status      = st;

  assign wr.en   = wr_en & ex_fire;
  assign wr.addr = arg;
  assign wr.data = top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      sp_r     <= '0;
      halted_r <= 1'b0;
    end else if (ex_fire) begin
      pc_r     <= pc_nxt;
      sp_r     <= sp_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire && push) begin
      sec_r <= top_r;
      top_r <= push_val;
    end
  end

endmodule

// ===== design/stack_machine_executor_core.sv =====
// channel | direction | handshake             | payload
// in_     | request   | in_valid / in_ready   | in_data  (opcode, operand)
// out_    | result    | out_valid / out_ready | out_data (next_pc, top_value, stack_count, status)
// one instruction per cycle sustained while the result is not stalled; result register loaded
// from the execute stage register when the request retires
// the data memory read is issued in the accept cycle
// after reset a clearing pass zeroes every data memory word, in_ready low
// a stalled result holds the execute stage, which then holds in_ready low
module stack_machine_executor_core #(
  parameter int STACK_DEPTH = smx_pkg::StackDepthDef,
  parameter int DATA_WORDS  = smx_pkg::DataWordsDef,
  parameter int PROG_WORDS  = smx_pkg::ProgWordsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smx_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output smx_pkg::out_rsp_t out_data
);

  import smx_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          ex_v_r, ex_v_nxt;
  in_req_t       ex_req_r;
  logic          fwd_r;
  logic [31:0]   fwd_data_r;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_data_r;

  logic          in_fire, ex_fire;
  logic [AW-1:0] rd_addr, ram_waddr;
  logic [31:0]   rd_data, ld_data, ram_wdata;
  logic          ram_we;
  out_rsp_t      rsp;
  mem_wr_t       wr;

  assign ex_fire  = ex_v_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_r && (!ex_v_r || ex_fire);
  assign in_fire  = in_valid && in_ready;
  assign rd_addr  = in_data.operand[AW-1:0];
  assign ld_data  = fwd_r ? fwd_data_r : rd_data;

  assign ram_we    = clr_r || wr.en;
  assign ram_waddr = clr_r ? clr_cnt_r : wr.addr[AW-1:0];
  assign ram_wdata = clr_r ? '0 : wr.data;

  smx_ram #(
    .WIDTH(32),
    .DEPTH(DATA_WORDS)
  ) u_dmem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  smx_exec #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WORDS (DATA_WORDS),
    .PROG_WORDS (PROG_WORDS)
  ) u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .ex_fire(ex_fire),
    .ex_req (ex_req_r),
    .ld_data(ld_data),
    .rsp    (rsp),
    .wr     (wr)
  );

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      if (clr_cnt_r == AW'(DATA_WORDS - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
    end
  end

  assign ex_v_nxt      = in_fire || (ex_v_r && !ex_fire);
  assign out_valid_nxt = ex_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      ex_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ex_v_r      <= ex_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result registers; forwarding of a same-cycle store to the address being read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_req_r   <= in_data;
      fwd_r      <= wr.en && (wr.addr[AW-1:0] == rd_addr);
      fwd_data_r <= wr.data;
    end
    if (ex_fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready && !ex_v_r)
    else $error("request taken during memory clear");

  a_ex_hold : assert property (@(posedge clk) disable iff (!rst_n)
    ex_v_r && !ex_fire |=> ex_v_r && $stable(ex_req_r))
    else $error("stalled execute stage lost its request");

  a_wr_retire : assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ex_fire && !clr_r)
    else $error("data memory store outside a retiring request");

endmodule
